[hdl/soa_pkg.sv]
// Shared types and constants for the slab object allocator.
package soa_pkg;

    localparam int HANDLE_W     = 10;
    localparam int OBJ_FIELD_W  = 8;   // object index field, covers up to 256 objects
    localparam int STATUS_W     = 2;
    localparam int OBJS_CFG_W   = 7;
    localparam int BUDGET_CFG_W = 5;
    localparam int CFG_DATA_W   = 7;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_OBJS_PER_SLAB = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLAB_BUDGET   = 1'b1;

    localparam logic [OBJS_CFG_W-1:0]   OBJS_CFG_RESET   = 7'd64;
    localparam logic [BUDGET_CFG_W-1:0] BUDGET_CFG_RESET = 5'd16;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_MEM   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

    // handle / OBJS_MAX is done as a multiply by a rounded-up reciprocal
    localparam int RECIP_SHIFT = 20;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic                action;
        logic [HANDLE_W-1:0] handle;
    } t_in_item;

    typedef struct packed {
        logic [HANDLE_W-1:0] object_handle;
        logic [STATUS_W-1:0] status;
        logic                grew;
    } t_out_item;

    typedef struct packed {
        logic                   is_free;
        logic [HANDLE_W-1:0]    slab;
        logic [OBJ_FIELD_W-1:0] obj;
    } t_cmd;

endpackage

[hdl/soa_front.sv]
// Front end: takes requests and splits a free handle into slab and object index.
module soa_front #(
    parameter int OBJS_MAX = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  soa_pkg::t_in_item i_item,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output soa_pkg::t_cmd     o_cmd
);

    localparam int PROD_W = soa_pkg::HANDLE_W + soa_pkg::RECIP_SHIFT + 1;
    localparam logic [soa_pkg::RECIP_SHIFT:0] RECIP =
        (soa_pkg::RECIP_SHIFT + 1)'((2 ** soa_pkg::RECIP_SHIFT + OBJS_MAX - 1) / OBJS_MAX);

    logic                         r_valid;
    soa_pkg::t_in_item            r_item;
    logic [soa_pkg::HANDLE_W-1:0] r_quot;
    logic [PROD_W-1:0]            w_prod;
    logic [soa_pkg::HANDLE_W-1:0] w_base;
    logic [soa_pkg::HANDLE_W-1:0] w_rem;

    // exact for any 10-bit handle since OBJS_MAX < 1024
    assign w_prod = PROD_W'(i_item.handle) * PROD_W'(RECIP);

    assign o_ready = !r_valid || i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
            r_quot <= w_prod[soa_pkg::RECIP_SHIFT +: soa_pkg::HANDLE_W];
        end
    end

    assign w_base = soa_pkg::HANDLE_W'(32'(r_quot) * OBJS_MAX);
    assign w_rem  = r_item.handle - w_base;

    assign o_cmd_valid   = r_valid;
    assign o_cmd.is_free = (r_item.action == soa_pkg::ACT_FREE);
    assign o_cmd.slab    = r_quot;
    assign o_cmd.obj     = soa_pkg::OBJ_FIELD_W'(w_rem);

endmodule

[hdl/soa_queue.sv]
// Short command queue between the front end and the slab engine.
module soa_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  soa_pkg::t_cmd i_data,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output soa_pkg::t_cmd o_data
);

    // depth is a power of two, pointers wrap on their own
    localparam int PTR_W = $clog2(soa_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(soa_pkg::QUEUE_DEPTH + 1);

    soa_pkg::t_cmd    r_slots [soa_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = (r_count != CNT_W'(soa_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;
    assign o_data       = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slots[r_wr_ptr] <= i_data;
        end
    end

endmodule

[hdl/soa_back.sv]
// Slab engine: slab search, slab growth, free-list pop and push, result register.
module soa_back #(
    parameter  int MAX_SLABS = 16,
    parameter  int OBJS_MAX  = 64,
    localparam int NW        = $clog2(OBJS_MAX + 1),
    localparam int GW        = $clog2(MAX_SLABS + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [NW-1:0]      i_n_objs,
    input  logic [GW-1:0]      i_budget,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  soa_pkg::t_cmd      i_cmd,
    output logic               o_valid,
    input  logic               i_ready,
    output soa_pkg::t_out_item o_item
);

    localparam int SW     = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
    localparam int OW     = $clog2(OBJS_MAX);
    localparam int AW     = SW + OW;
    localparam int MEM_D  = MAX_SLABS * (2 ** OW);
    localparam int HP_W   = ($clog2(MAX_SLABS * OBJS_MAX) > soa_pkg::HANDLE_W) ?
                            $clog2(MAX_SLABS * OBJS_MAX) : soa_pkg::HANDLE_W;
    localparam logic [NW-1:0] EMPTY = NW'(OBJS_MAX);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECIDE = 5'b00010,
        S_GROW   = 5'b00100,
        S_POP    = 5'b01000,
        S_OUT    = 5'b10000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [GW-1:0]      r_grown;
    logic [NW-1:0]      r_count [MAX_SLABS];
    logic [NW-1:0]      r_head  [MAX_SLABS];
    logic [NW-1:0]      r_link_mem [MEM_D];
    logic [NW-1:0]      r_rd_data;
    soa_pkg::t_cmd      r_cmd;
    logic [SW-1:0]      r_slab;
    logic [OW-1:0]      r_idx;
    logic [OW-1:0]      r_obj;
    soa_pkg::t_out_item r_out;

    logic [SW-1:0]   w_free_slab;
    logic [OW-1:0]   w_free_obj;
    logic            w_free_bad;
    logic            w_found;
    logic [SW-1:0]   w_sel;
    logic [NW-1:0]   w_sel_head;
    logic            w_can_grow;
    logic            w_last_link;
    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [NW-1:0]   w_wdata;
    logic            w_re;
    logic [AW-1:0]   w_raddr;
    logic [HP_W-1:0] w_hsum;

    assign w_free_slab = r_cmd.slab[SW-1:0];
    assign w_free_obj  = r_cmd.obj[OW-1:0];
    assign w_free_bad  = (r_cmd.slab >= soa_pkg::HANDLE_W'(r_grown)) ||
                         (r_count[w_free_slab] == '0);
    assign w_can_grow  = (r_grown < i_budget);
    assign w_last_link = (NW'(r_idx) == i_n_objs - NW'(1));
    assign w_sel_head  = r_head[w_sel];

    // newest grown slab with room wins
    always_comb begin
        w_found = 1'b0;
        w_sel   = '0;
        for (int i = 0; i < MAX_SLABS; i++) begin
            if ((i < int'(r_grown)) && (r_count[i] < i_n_objs) && (r_head[i] != EMPTY)) begin
                w_found = 1'b1;
                w_sel   = SW'(i);
            end
        end
    end

    assign w_hsum = HP_W'(r_slab) * HP_W'(OBJS_MAX) + HP_W'(r_obj);

    // link memory ports
    always_comb begin
        w_we    = 1'b0;
        w_waddr = {w_free_slab, w_free_obj};
        w_wdata = r_head[w_free_slab];
        w_re    = 1'b0;
        w_raddr = {w_sel, w_sel_head[OW-1:0]};
        case (r_state)
            S_DECIDE: begin
                if (r_cmd.is_free) begin
                    w_we = !w_free_bad;
                end else begin
                    w_re = w_found;
                end
            end
            S_GROW: begin
                w_we    = 1'b1;
                w_waddr = {r_slab, r_idx};
                w_wdata = w_last_link ? EMPTY : NW'(r_idx) + NW'(1);
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_link_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_link_mem[w_raddr];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (r_cmd.is_free) begin
                    n_state = S_OUT;
                end else if (w_found) begin
                    n_state = S_POP;
                end else if (w_can_grow) begin
                    n_state = S_GROW;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_GROW: begin
                if (w_last_link) begin
                    n_state = S_OUT;
                end
            end
            S_POP: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_grown <= '0;
            for (int i = 0; i < MAX_SLABS; i++) begin
                r_count[i] <= '0;
                r_head[i]  <= EMPTY;
            end
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                    end
                end
                S_DECIDE: begin
                    r_out.object_handle <= '0;
                    r_out.grew          <= 1'b0;
                    if (r_cmd.is_free) begin
                        if (w_free_bad) begin
                            r_out.status <= soa_pkg::STATUS_BAD_FREE;
                        end else begin
                            r_out.status         <= soa_pkg::STATUS_OK;
                            r_head[w_free_slab]  <= NW'(w_free_obj);
                            r_count[w_free_slab] <= r_count[w_free_slab] - NW'(1);
                        end
                    end else if (w_found) begin
                        r_out.status <= soa_pkg::STATUS_OK;
                        r_slab       <= w_sel;
                        r_obj        <= w_sel_head[OW-1:0];
                    end else if (w_can_grow) begin
                        r_out.status <= soa_pkg::STATUS_OK;
                        r_slab       <= r_grown[SW-1:0];
                        r_idx        <= '0;
                        r_obj        <= '0;
                    end else begin
                        r_out.status <= soa_pkg::STATUS_NO_MEM;
                    end
                end
                S_GROW: begin
                    r_idx <= r_idx + OW'(1);
                    if (w_last_link) begin
                        // object 0 goes out at once; the list continues at 1
                        r_head[r_slab]      <= (i_n_objs == NW'(1)) ? EMPTY : NW'(1);
                        r_count[r_slab]     <= NW'(1);
                        r_grown             <= r_grown + GW'(1);
                        r_out.object_handle <= w_hsum[soa_pkg::HANDLE_W-1:0];
                        r_out.status        <= soa_pkg::STATUS_OK;
                        r_out.grew          <= 1'b1;
                    end
                end
                S_POP: begin
                    r_head[r_slab]      <= r_rd_data;
                    r_count[r_slab]     <= r_count[r_slab] + NW'(1);
                    r_out.object_handle <= w_hsum[soa_pkg::HANDLE_W-1:0];
                    r_out.status        <= soa_pkg::STATUS_OK;
                    r_out.grew          <= 1'b0;
                end
                default: begin
                    r_grown <= r_grown;
                end
            endcase
        end
    end

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_valid     = (r_state == S_OUT);
    assign o_item      = r_out;

endmodule

[hdl/slab_object_allocator_core.sv]
// Path: front register, queue, then the engine states idle, decide and out for a free or a
// failed allocate, with a pop state before out for an allocate from a slab with room, or a
// grow state writing the new slab's link list (one link write per cycle) for one that grows
// a slab. The engine takes no new beat until its result is taken, and a held result stalls
// it. Front register and 2-entry queue buffer up to 3 beats behind it. Reset (synchronous,
// active low) empties all slabs and restores the register defaults, not the link memory.
module slab_object_allocator_core #(
    parameter int MAX_SLABS = 16,
    parameter int OBJS_MAX  = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [soa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [soa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  soa_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output soa_pkg::t_out_item              o_out_data
);

    localparam int NW = $clog2(OBJS_MAX + 1);
    localparam int GW = $clog2(MAX_SLABS + 1);

    logic [soa_pkg::OBJS_CFG_W-1:0]   r_objs_per_slab;
    logic [soa_pkg::BUDGET_CFG_W-1:0] r_slab_budget;
    logic [NW-1:0]                    w_n_objs;
    logic [GW-1:0]                    w_budget;

    logic          w_cmd_valid;
    logic          w_cmd_ready;
    soa_pkg::t_cmd w_cmd;
    logic          w_q_valid;
    logic          w_q_ready;
    soa_pkg::t_cmd w_q_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_objs_per_slab <= soa_pkg::OBJS_CFG_RESET;
            r_slab_budget   <= soa_pkg::BUDGET_CFG_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                soa_pkg::CFG_OBJS_PER_SLAB: begin
                    r_objs_per_slab <= i_cfg_data[soa_pkg::OBJS_CFG_W-1:0];
                end
                soa_pkg::CFG_SLAB_BUDGET: begin
                    r_slab_budget <= i_cfg_data[soa_pkg::BUDGET_CFG_W-1:0];
                end
                default: begin
                    r_slab_budget <= r_slab_budget;
                end
            endcase
        end
    end

    // zero objects counts as one; both registers saturate at the build limits
    always_comb begin
        if (r_objs_per_slab == '0) begin
            w_n_objs = NW'(1);
        end else if (r_objs_per_slab > OBJS_MAX) begin
            w_n_objs = NW'(OBJS_MAX);
        end else begin
            w_n_objs = NW'(r_objs_per_slab);
        end
        if (r_slab_budget > MAX_SLABS) begin
            w_budget = GW'(MAX_SLABS);
        end else begin
            w_budget = GW'(r_slab_budget);
        end
    end

    soa_front #(
        .OBJS_MAX(OBJS_MAX)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_ready    (o_in_ready),
        .i_item     (i_in_data),
        .o_cmd_valid(w_cmd_valid),
        .i_cmd_ready(w_cmd_ready),
        .o_cmd      (w_cmd)
    );

    soa_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_valid(w_cmd_valid),
        .o_push_ready(w_cmd_ready),
        .i_data      (w_cmd),
        .o_pop_valid (w_q_valid),
        .i_pop_ready (w_q_ready),
        .o_data      (w_q_cmd)
    );

    soa_back #(
        .MAX_SLABS(MAX_SLABS),
        .OBJS_MAX (OBJS_MAX)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_n_objs   (w_n_objs),
        .i_budget   (w_budget),
        .i_cmd_valid(w_q_valid),
        .o_cmd_ready(w_q_ready),
        .i_cmd      (w_q_cmd),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_item     (o_out_data)
    );

endmodule
